### design/szbw_pkg.sv
// Shared types and constants for the secure zone border wrapper.
package szbw_pkg;

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_UNSET = 1'b1
  } cmd_t;

  // Configuration register indexes
  localparam logic CFG_NODE_X = 1'b0;
  localparam logic CFG_NODE_Y = 1'b1;

  // Border isolation bits, two per port: S N W E
  localparam logic [7:0] BORDER_E = 8'h03;
  localparam logic [7:0] BORDER_W = 8'h0C;
  localparam logic [7:0] BORDER_N = 8'h30;
  localparam logic [7:0] BORDER_S = 8'hC0;

  localparam logic [7:0] CORNER_RESET = 8'hFF;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  ll_corner;
    logic [7:0]  rh_corner;
    logic [15:0] master_address;
  } item_t;

  typedef struct packed {
    logic [7:0]  port_mask;
    logic        mask_write;
    logic        clear_request;
    logic        set_ack;
    logic        zone_closed;
    logic [15:0] notify_target;
    logic [7:0]  report_corner;
  } result_t;

endpackage

### design/szbw_in_stage.sv
// Input register: holds one command beat until the core takes it.
module szbw_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  szbw_pkg::item_t in_item,
  input  logic            advance,
  output logic            held_valid,
  output szbw_pkg::item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

### design/szbw_core.sv
// Border decode, mask update and zone state for one mesh node.
module szbw_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              fire,
  input  szbw_pkg::item_t   item,
  output szbw_pkg::result_t result
);

  logic [3:0] node_x;
  logic [3:0] node_y;
  logic [7:0] isolation_mask;
  logic [7:0] zone_low_corner;
  logic [7:0] zone_high_corner;
  logic       zone_known;

  logic [3:0] lx, ly, hx, hy, sx, sy;
  logic       at_rh, outside, set_take;
  logic [7:0] ports;
  logic       at_local_rh, no_cut, mine, mask_nz;
  logic       add_w, add_s, sub_w, sub_s, in_y_range;
  logic [7:0] unset_mask;

  assign lx = item.ll_corner[7:4];
  assign ly = item.ll_corner[3:0];
  assign hx = item.rh_corner[7:4];
  assign hy = item.rh_corner[3:0];
  assign sx = zone_high_corner[7:4];
  assign sy = zone_high_corner[3:0];

  // Set path
  assign at_rh   = (node_x == hx) && (node_y == hy);
  assign outside = (node_x > hx) || (node_y > hy) || (node_x < lx) || (node_y < ly);
  assign ports   = ((node_x == hx) ? szbw_pkg::BORDER_E : 8'h00)
                 | ((node_x == lx) ? szbw_pkg::BORDER_W : 8'h00)
                 | ((node_y == hy) ? szbw_pkg::BORDER_N : 8'h00)
                 | ((node_y == ly) ? szbw_pkg::BORDER_S : 8'h00);
  assign set_take = !outside && (ports != 8'h00);

  // Unset path
  assign at_local_rh = zone_known && (node_x == sx) && (node_y == sy);
  assign no_cut      = zone_known && (item.rh_corner == item.ll_corner)
                    && (zone_high_corner == item.rh_corner);
  assign mine        = no_cut ? (at_local_rh && at_rh)
                              : (at_local_rh && (item.ll_corner == zone_low_corner));
  assign mask_nz     = (isolation_mask != 8'h00);

  // Neighbor checks use one extra bit so that a corner at 15 never matches
  assign in_y_range = (node_y >= ly) && (node_y <= hy);
  assign add_w = ({1'b0, node_x} == ({1'b0, lx} + 5'd1)) && in_y_range;
  assign add_s = ({1'b0, node_y} == ({1'b0, hy} + 5'd1)) && (node_x == hx);
  assign sub_w = (node_x == lx) && in_y_range;
  assign sub_s = (node_y == ly) && (node_x == lx);

  assign unset_mask = isolation_mask
                    + (add_w ? szbw_pkg::BORDER_W : 8'h00)
                    + (add_s ? szbw_pkg::BORDER_S : 8'h00)
                    - (sub_w ? szbw_pkg::BORDER_W : 8'h00)
                    - (sub_s ? szbw_pkg::BORDER_S : 8'h00);

  always_comb begin
    result = '0;
    unique case (item.cmd)
      szbw_pkg::CMD_SET: begin
        result.clear_request = at_rh;
        result.port_mask     = set_take ? ports : isolation_mask;
        if (set_take && at_rh) begin
          result.set_ack       = 1'b1;
          result.report_corner = item.rh_corner;
        end
      end
      szbw_pkg::CMD_UNSET: begin
        result.clear_request = mine;
        result.port_mask     = mask_nz ? unset_mask : isolation_mask;
        result.mask_write    = mask_nz;
        if (mask_nz && mine) begin
          result.zone_closed   = 1'b1;
          result.report_corner = zone_high_corner;
        end
      end
    endcase
    if (result.clear_request || result.set_ack || result.zone_closed) begin
      result.notify_target = item.master_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_x <= 4'd0;
      node_y <= 4'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        szbw_pkg::CFG_NODE_X: node_x <= cfg_data;
        szbw_pkg::CFG_NODE_Y: node_y <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      isolation_mask   <= 8'h00;
      zone_low_corner  <= szbw_pkg::CORNER_RESET;
      zone_high_corner <= szbw_pkg::CORNER_RESET;
      zone_known       <= 1'b0;
    end else if (fire) begin
      isolation_mask <= result.port_mask;
      if (item.cmd == szbw_pkg::CMD_SET && set_take) begin
        zone_low_corner  <= item.ll_corner;
        zone_high_corner <= item.rh_corner;
        zone_known       <= 1'b1;
      end
    end
  end

endmodule

### design/szbw_out_stage.sv
// Result register: holds one result beat until the receiver takes it.
module szbw_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  szbw_pkg::result_t load_result,
  input  logic              out_ready,
  output logic              out_valid,
  output szbw_pkg::result_t out_result,
  output logic              free
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

### design/secure_zone_border_wrapper.sv
// Top level of the secure zone border wrapper for one mesh node.
//
// Usage:
//   s_axis carries one set or unset command per beat; tuser is the command,
//   tdata holds both zone corners and the master address. Each accepted
//   beat yields exactly one m_axis beat: tdata holds the new isolation
//   mask, the notification target and the reported corner, tuser holds the
//   write strobe and the three message flags.
//   The cfg channel writes node_x (index 0) or node_y (index 1); it is
//   always ready and must only be used while no command is in flight.
// Pipeline and throughput:
//   A command is held in the input register while the core decodes it;
//   the result register loads the decoded result once it has room, and the
//   result beat is presented from there. One command per cycle is
//   sustained while m_axis_tready stays high; the zone state updates
//   as the result register loads, so back-to-back commands see it at once.
// Reset: rst is synchronous; it empties both registers, clears the mask,
//   sets both stored corners to 0xFF and the node coordinates to zero.
// Stall: while m_axis_tready is low the result holds; one more command
//   waits in the input register, then s_axis_tready drops.
module secure_zone_border_wrapper (
  input  logic        clk,
  input  logic        rst,
  // Command channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // ll_corner[7:0], rh_corner[15:8], master_address[31:16]
  input  logic        s_axis_tuser,   // cmd[0]
  // Result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // port_mask[7:0], notify_target[23:8], report_corner[31:24]
  output logic [3:0]  m_axis_tuser,   // mask_write[0], clear_request[1], set_ack[2], zone_closed[3]
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  szbw_pkg::item_t   in_item;
  szbw_pkg::item_t   held_item;
  szbw_pkg::result_t core_result;
  szbw_pkg::result_t out_result;
  logic              held_valid;
  logic              out_free;
  logic              advance;

  // Unpack the command beat
  assign in_item.cmd            = szbw_pkg::cmd_t'(s_axis_tuser);
  assign in_item.ll_corner      = s_axis_tdata[7:0];
  assign in_item.rh_corner      = s_axis_tdata[15:8];
  assign in_item.master_address = s_axis_tdata[31:16];

  // Move the held command into the result register when it has room
  assign advance   = held_valid && out_free;
  assign cfg_ready = 1'b1;

  szbw_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  szbw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (held_item),
    .result    (core_result)
  );

  szbw_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .load_result (core_result),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_result  (out_result),
    .free        (out_free)
  );

  // Pack the result beat
  assign m_axis_tdata = {out_result.report_corner, out_result.notify_target,
                         out_result.port_mask};
  assign m_axis_tuser = {out_result.zone_closed, out_result.set_ack,
                         out_result.clear_request, out_result.mask_write};

`ifndef ASSERT_OFF
  // An empty result register never blocks the command side
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("command side stalled with empty result register");

  // A held command with room downstream shows up as a result next cycle
  a_advance_to_out: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("held command did not reach the result register");

  // Acknowledge and close never come from the same command
  a_ack_close_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_result.set_ack && out_result.zone_closed))
    else $error("set_ack and zone_closed both raised");

  // A set acknowledge never writes the wrapper register
  a_ack_no_write: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_result.set_ack) |-> !out_result.mask_write)
    else $error("set_ack with mask_write");

  // A close is always a written mask
  a_close_writes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_result.zone_closed) |-> out_result.mask_write)
    else $error("zone_closed without mask_write");

  // A corner is reported only with an acknowledge or a close
  a_corner_gated: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_result.report_corner != 8'h00)
      |-> (out_result.set_ack || out_result.zone_closed))
    else $error("report_corner set without ack or close");
`endif

endmodule

### tb/secure_zone_border_wrapper_test.sv
// Self-checking testbench for the secure zone border wrapper.
`timescale 1ns / 100ps

module secure_zone_border_wrapper_test;

  localparam int WATCHDOG_LIMIT = 1500;  // beat-free cycles before giving up
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int PHASE_ITEMS    = 80;
  localparam int NUM_PHASES     = 8;
  localparam int SETTLE_CYCLES  = 4;     // pipeline drain plus margin

  // Tracks the zone state of one node and holds the results it predicts.
  class zone_tracker;
    logic [3:0]        node_x;
    logic [3:0]        node_y;
    logic [7:0]        iso_mask;
    logic [7:0]        low_corner;
    logic [7:0]        high_corner;
    bit                zone_known;
    szbw_pkg::result_t pending_results[$];
    int                errors;

    function new();
      node_x      = '0;
      node_y      = '0;
      iso_mask    = '0;
      low_corner  = szbw_pkg::CORNER_RESET;
      high_corner = szbw_pkg::CORNER_RESET;
      zone_known  = 1'b0;
      errors      = 0;
    endfunction

    function void set_coord(logic idx, logic [3:0] value);
      if (idx == szbw_pkg::CFG_NODE_X) begin
        node_x = value;
      end else begin
        node_y = value;
      end
    endfunction

    // Predict the result of one accepted command and queue it.
    function void note_command(szbw_pkg::item_t c);
      szbw_pkg::result_t r;
      logic [3:0]        lx, ly, hx, hy, sx, sy;
      logic [7:0]        ports;
      logic [7:0]        m;
      bit                at_rh, at_home_rh, no_cut, mine;
      r  = '0;
      lx = c.ll_corner[7:4];
      ly = c.ll_corner[3:0];
      hx = c.rh_corner[7:4];
      hy = c.rh_corner[3:0];
      if (c.cmd == szbw_pkg::CMD_SET) begin
        at_rh = (node_x == hx) && (node_y == hy);
        r.clear_request = at_rh;
        if (!(node_x > hx || node_y > hy || node_x < lx || node_y < ly)) begin
          ports = '0;
          if (node_x == hx) ports += szbw_pkg::BORDER_E;
          if (node_x == lx) ports += szbw_pkg::BORDER_W;
          if (node_y == hy) ports += szbw_pkg::BORDER_N;
          if (node_y == ly) ports += szbw_pkg::BORDER_S;
          // Interior nodes lie on no border and keep their state.
          if (ports != '0) begin
            iso_mask    = ports;
            low_corner  = c.ll_corner;
            high_corner = c.rh_corner;
            zone_known  = 1'b1;
            if (at_rh) begin
              r.set_ack       = 1'b1;
              r.report_corner = high_corner;
            end
          end
        end
      end else begin
        sx = high_corner[7:4];
        sy = high_corner[3:0];
        at_home_rh = zone_known && node_x == sx && node_y == sy;
        no_cut = zone_known && (c.rh_corner == c.ll_corner) && (high_corner == c.rh_corner);
        if (no_cut) begin
          mine = at_home_rh && node_x == hx && node_y == hy;
        end else begin
          mine = at_home_rh && (c.ll_corner == low_corner);
        end
        r.clear_request = mine;
        if (iso_mask != '0) begin
          // Border bits move with the cut; the 8-bit sum wraps on its own.
          m = iso_mask;
          if (int'(node_x) == int'(lx) + 1 && node_y >= ly && node_y <= hy)
            m += szbw_pkg::BORDER_W;
          if (int'(node_y) == int'(hy) + 1 && node_x == hx) m += szbw_pkg::BORDER_S;
          if (node_x == lx && node_y >= ly && node_y <= hy) m -= szbw_pkg::BORDER_W;
          if (node_y == ly && node_x == lx) m -= szbw_pkg::BORDER_S;
          iso_mask     = m;
          r.mask_write = 1'b1;
          if (mine) begin
            r.zone_closed   = 1'b1;
            r.report_corner = high_corner;
          end
        end
      end
      r.port_mask = iso_mask;
      if (r.clear_request || r.set_ack || r.zone_closed) r.notify_target = c.master_address;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compare one result beat against the oldest prediction.
    task check_result(szbw_pkg::result_t got);
      szbw_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", got));
      end else begin
        want = pending_results.pop_front();
        compare_field("port_mask", got.port_mask, want.port_mask);
        compare_field("mask_write", got.mask_write, want.mask_write);
        compare_field("clear_request", got.clear_request, want.clear_request);
        compare_field("set_ack", got.set_ack, want.set_ack);
        compare_field("zone_closed", got.zone_closed, want.zone_closed);
        compare_field("notify_target", got.notify_target, want.notify_target);
        compare_field("report_corner", got.report_corner, want.report_corner);
      end
    endtask
  endclass

  // Clock, reset and block ports. Every input holds a known value from time zero.
  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // ll_corner[7:0], rh_corner[15:8], master_address[31:16]
  logic        s_axis_tuser  = 1'b0; // cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // port_mask[7:0], notify_target[23:8], report_corner[31:24]
  logic [3:0]  m_axis_tuser;         // mask_write[0], clear_request[1], set_ack[2], zone_closed[3]
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = szbw_pkg::CFG_NODE_X;
  logic [3:0]  cfg_data      = '0;

  zone_tracker tracker = new();

  // Idle controls, changed per phase by the stimulus process.
  int gap_pct       = 0;    // chance of a sender gap before a command
  int stall_pct     = 0;    // chance per cycle that the receiver starts a stall
  bit hold_request  = 1'b0; // ask the receiver for one long hold-off
  int idle_cycles   = 0;

  secure_zone_border_wrapper dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: check every result beat, then pick the next tready. All
  // sampling happens right after the edge, before any NBA of that step.
  initial begin
    int                stall_left;
    szbw_pkg::result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.port_mask     = m_axis_tdata[7:0];
        got.notify_target = m_axis_tdata[23:8];
        got.report_corner = m_axis_tdata[31:24];
        got.mask_write    = m_axis_tuser[0];
        got.clear_request = m_axis_tuser[1];
        got.set_ack       = m_axis_tuser[2];
        got.zone_closed   = m_axis_tuser[3];
        tracker.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        // Long hold-off so the input register fills and tready drops.
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("secure_zone_border_wrapper_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic szbw_pkg::item_t make_item(szbw_pkg::cmd_t cmd, logic [7:0] ll,
                                                logic [7:0] rh, logic [15:0] master);
    szbw_pkg::item_t c;
    c.cmd            = cmd;
    c.ll_corner      = ll;
    c.rh_corner      = rh;
    c.master_address = master;
    return c;
  endfunction

  // Random coordinate within a window around base, clamped to the mesh.
  function automatic logic [3:0] near(int base, int below, int above);
    int lo, hi;
    lo = (base - below < 0) ? 0 : base - below;
    hi = (base + above > 15) ? 15 : base + above;
    return 4'($urandom_range(hi, lo));
  endfunction

  // Mostly commands that touch this node's zone, plus some raw noise.
  function automatic szbw_pkg::item_t random_item();
    szbw_pkg::item_t c;
    int              kind;
    int              nx, ny;
    logic [3:0]      lx, ly, hx, hy;
    nx = tracker.node_x;
    ny = tracker.node_y;
    kind = $urandom_range(0, 99);
    c.master_address = 16'($urandom);
    if ($urandom_range(0, 15) == 0) c.master_address = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    lx = near(nx, 2, 0);
    ly = near(ny, 2, 0);
    hx = near(nx, 0, 2);
    hy = near(ny, 0, 2);
    if (kind < 40) begin
      // Open a zone around this node, often with the node as upper-right corner.
      c.cmd = szbw_pkg::CMD_SET;
      if ($urandom_range(0, 2) == 0) begin
        hx = 4'(nx);
        hy = 4'(ny);
      end
      c.ll_corner = {lx, ly};
      c.rh_corner = {hx, hy};
    end else if (kind < 75) begin
      c.cmd = szbw_pkg::CMD_UNSET;
      case ($urandom_range(0, 3))
        0: begin
          // Close the stored zone outright.
          c.ll_corner = tracker.high_corner;
          c.rh_corner = tracker.high_corner;
        end
        1: begin
          c.ll_corner = tracker.low_corner;
          c.rh_corner = $urandom_range(0, 1) ? tracker.high_corner : {hx, hy};
        end
        2: begin
          // Cut a column at or just west of this node.
          c.ll_corner = {near(nx, 1, 0), ly};
          c.rh_corner = {hx, hy};
        end
        default: begin
          // Cut a row at or just south of this node.
          c.ll_corner = {lx, ly};
          c.rh_corner = {4'(nx), near(ny, 1, 0)};
        end
      endcase
    end else begin
      c.cmd       = szbw_pkg::cmd_t'($urandom_range(0, 1));
      c.ll_corner = 8'($urandom);
      c.rh_corner = 8'($urandom);
    end
    return c;
  endfunction

  // Offer one command, optionally after a gap, and wait for its beat.
  // tvalid stays high afterwards so back-to-back commands need no toggle.
  task send_command(szbw_pkg::item_t c, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.master_address, c.rh_corner, c.ll_corner};
    s_axis_tuser  <= c.cmd;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_command(c);
  endtask

  task send_random(int count);
    repeat (count) begin
      send_command(random_item(),
                   ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 16) : 0);
    end
  endtask

  // Drop tvalid and wait until every predicted result has been seen.
  task drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both node coordinates back to back; only call while drained.
  task write_node(logic [3:0] x, logic [3:0] y);
    cfg_valid <= 1'b1;
    cfg_index <= szbw_pkg::CFG_NODE_X;
    cfg_data  <= x;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_coord(szbw_pkg::CFG_NODE_X, x);
    cfg_index <= szbw_pkg::CFG_NODE_Y;
    cfg_data  <= y;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_coord(szbw_pkg::CFG_NODE_Y, y);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [3:0] xs[NUM_PHASES];
    logic [3:0] ys[NUM_PHASES];
    xs = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd7, 4'd0, 4'd0, 4'd0};
    ys = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd9, 4'd0, 4'd0, 4'd0};
    for (int i = 5; i < NUM_PHASES; i++) begin
      xs[i] = 4'($urandom_range(0, 15));
      ys[i] = 4'($urandom_range(0, 15));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, node at (5,6). Comments give the expected behavior.
    write_node(4'd5, 4'd6);
    stall_pct = 10;
    // no zone, zero mask
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h00, 8'hFF, 16'hFFFF), 0);
    // interior: no change
    send_command(make_item(szbw_pkg::CMD_SET, 8'h00, 8'hFF, 16'h0000), 0);
    // outside
    send_command(make_item(szbw_pkg::CMD_SET, 8'h78, 8'h9A, 16'h1111), 0);
    // reversed at upper-right
    send_command(make_item(szbw_pkg::CMD_SET, 8'h9A, 8'h56, 16'h2222), 0);
    // single node, all borders
    send_command(make_item(szbw_pkg::CMD_SET, 8'h56, 8'h56, 16'hA5A5), 0);
    // full close of own zone
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h56, 8'h56, 16'h5A5A), 0);
    // subtraction wraps
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h56, 8'h56, 16'h3333), 2);
    // E, N and S borders
    send_command(make_item(szbw_pkg::CMD_SET, 8'h06, 8'h56, 16'h1234), 0);
    // cut west neighbor
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h46, 8'h46, 16'h4444), 0);
    // own zone, add S wraps
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h06, 8'h55, 16'hBEEF), 0);
    // W and N, not at corner
    send_command(make_item(szbw_pkg::CMD_SET, 8'h50, 8'hF6, 16'h5555), 0);
    // unrelated cut, write only
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'hF0, 8'hFF, 16'hFFFF), 0);
    // reversed elsewhere
    send_command(make_item(szbw_pkg::CMD_SET, 8'hFF, 8'h00, 16'h6666), 0);
    // E and N at corner
    send_command(make_item(szbw_pkg::CMD_SET, 8'h00, 8'h56, 16'h7777), 1);
    // close by stored low corner
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h00, 8'h56, 16'h8888), 0);
    // W only
    send_command(make_item(szbw_pkg::CMD_SET, 8'h50, 8'h9F, 16'h9999), 0);
    // mask back to zero
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h50, 8'h9F, 16'hAAAA), 0);
    // zero mask: no write
    send_command(make_item(szbw_pkg::CMD_UNSET, 8'h50, 8'h9F, 16'hCCCC), 0);
    drain();

    // Random phases; each one rewrites the node coordinates while idle.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_node(xs[p], ys[p]);
      case (p % 3)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 30; stall_pct = 8;  end
        default: begin gap_pct = 10; stall_pct = 25; end
      endcase
      // Keep the tail of the run free of idling on both sides.
      if (p >= NUM_PHASES - 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if (p == 1) begin
        // Fill the block against a stalled receiver, then wait it out.
        hold_request = 1'b1;
        send_random(30);
        drain();
      end
      send_random(PHASE_ITEMS);
      drain();
    end

    if (tracker.pending_results.size() != 0) tracker.report("results still expected at end");
    if (tracker.errors == 0) begin
      $display("secure_zone_border_wrapper_test: PASS");
    end else begin
      $display("secure_zone_border_wrapper_test: FAIL");
    end
    $finish;
  end

endmodule
